>>> rtl/core/bounded_ordered_list_defines.svh
// Assertion helpers used by the list RTL.
`ifndef BOUNDED_ORDERED_LIST_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bol_pkg.sv
package bol_pkg;

  // operation codes
  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_POS  = 3'd2;
  localparam logic [2:0] OP_DEL_POS  = 3'd3;
  localparam logic [2:0] OP_DUMP     = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a gap at pos, load new value there
    logic del;  // close the gap at pos
    logic rot;  // rotate the occupied cells toward the head by one
  } cell_ctl_t;

endpackage

>>> rtl/core/bol_cell.sv
module bol_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic               clk,
  input  bol_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      pos,
  input  logic [CW-1:0]      count,
  input  logic signed [31:0] new_value,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  input  logic signed [31:0] head,
  output logic signed [31:0] q
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic signed [31:0] q_next;
  logic [CW-1:0]      last_idx;

  assign last_idx = count - CW'(1);

  always_comb begin
    q_next = q;
    if (ctl.ins) begin
      if (IDX_C > pos) begin
        q_next = left;
      end else if (IDX_C == pos) begin
        q_next = new_value;
      end
    end else if (ctl.del) begin
      if (IDX_C >= pos) begin
        q_next = right;
      end
    end else if (ctl.rot) begin
      // tail takes the head value, the cells before it move one toward the head
      if (IDX_C == last_idx) begin
        q_next = head;
      end else if (IDX_C < last_idx) begin
        q_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/core/bounded_ordered_list.sv
// Bounded ordered list of up to CAPACITY signed 32-bit values, kept in a row
// of cells with the head in cell 0. Each input transfer carries one operation:
// insert at head, insert at tail, insert at a position (a position past the
// tail appends), delete at a position, dump, or clear. Every operation other
// than a dump returns one result, flagged last. A dump returns one result per
// element in head-to-tail order, the last one flagged; an empty dump returns a
// single result with element_valid low. Inserts and deletes need no
// sequencing: all cells compare their index to the position at once and shift
// toward their neighbor, so with out_ready held high the block takes one
// non-dump item per cycle. A dump first enters the dump state; then, whenever
// the output slot is free, the chain rotates by one and cell 0 is presented at
// the output; after one rotation per element the list is back in its original
// order. The output register frees the input side as soon as its result is
// taken. Cells past the tail hold stale data and are never shown.
module bounded_ordered_list #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  input  logic [15:0]        position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [5:0]         length,
  output logic signed [31:0] element,
  output logic               element_valid,
  output logic               last
);

`include "bounded_ordered_list_defines.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // controller states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] dump_idx, dump_idx_next;
  logic [CW-1:0] cell_pos, ins_pos;
  logic [15:0]   count16;
  bol_pkg::cell_ctl_t ctl;
  logic signed [31:0] cell_q [CAPACITY];

  logic in_xfer, slot_free, load_out;
  logic [1:0]         r_status;
  logic signed [31:0] r_element;
  logic               r_valid, r_last;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign in_xfer   = in_valid && in_ready;
  assign count16   = 16'(count);
  // insert position clamped to the tail
  assign ins_pos   = (position > count16) ? count : position[CW-1:0];

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    ctl           = '0;
    cell_pos      = ins_pos;
    load_out      = 1'b0;
    r_status      = bol_pkg::STAT_OK;
    r_element     = '0;
    r_valid       = 1'b0;
    r_last        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (operation) inside
            bol_pkg::OP_INS_HEAD, bol_pkg::OP_INS_TAIL, bol_pkg::OP_INS_POS: begin
              load_out = 1'b1;
              if (count == CAP_C) begin
                r_status = bol_pkg::STAT_FULL;
              end else begin
                ctl.ins    = 1'b1;
                count_next = count + CW'(1);
                if (operation == bol_pkg::OP_INS_HEAD) begin
                  cell_pos = '0;
                end else if (operation == bol_pkg::OP_INS_TAIL) begin
                  cell_pos = count;
                end
              end
            end
            bol_pkg::OP_DEL_POS: begin
              load_out = 1'b1;
              if (position >= count16) begin
                r_status = bol_pkg::STAT_NOTFOUND;
              end else begin
                ctl.del    = 1'b1;
                cell_pos   = position[CW-1:0];
                count_next = count - CW'(1);
              end
            end
            bol_pkg::OP_DUMP: begin
              if (count == '0) begin
                load_out = 1'b1;
              end else begin
                state_next    = ST_DUMP;
                dump_idx_next = '0;
              end
            end
            bol_pkg::OP_CLEAR: begin
              load_out   = 1'b1;
              count_next = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          // present head, rotate chain so the next element reaches cell 0
          load_out      = 1'b1;
          r_element     = cell_q[0];
          r_valid       = 1'b1;
          r_last        = (dump_idx == count - CW'(1));
          ctl.rot       = 1'b1;
          dump_idx_next = dump_idx + CW'(1);
          if (r_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each new result
  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= r_status;
      length        <= 6'(count_next);
      element       <= r_element;
      element_valid <= r_valid;
      last          <= r_last;
    end
  end

  // the cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = value;
    end else begin : g_mid
      assign left_v = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = cell_q[g];
    end else begin : g_inner
      assign right_v = cell_q[g+1];
    end
    bol_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cell_pos),
      .count     (count),
      .new_value (value),
      .left      (left_v),
      .right     (right_v),
      .head      (cell_q[0]),
      .q         (cell_q[g])
    );
  end

  `BOL_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "element count above capacity")
  `BOL_ASSERT_NOW(a_dump_nonempty, state == ST_DUMP, count != '0, "dump with empty list")
  `BOL_ASSERT_NEXT(a_full_refused, in_xfer && count == CAP_C && operation != bol_pkg::OP_DEL_POS && operation != bol_pkg::OP_CLEAR, $stable(count), "insert changed a full list")
  `BOL_ASSERT_NOW(a_midresult_dump, out_valid && !last, state == ST_DUMP, "non-last result outside dump")

endmodule
